### rtl/swbp_pkg.sv
// Shared widths, field layout and result type for the sliding-window projection core.
package swbp_pkg;

  localparam int MAX_FRAME_DIMS    = 256;
  localparam int MAX_WINDOW_FRAMES = 16;
  localparam int MAX_OFFSET        = 15;
  localparam int MAX_BASIS         = 8;
  localparam int SAMPLE_BITS       = 16;

  localparam int RING_FRAMES = MAX_WINDOW_FRAMES + MAX_OFFSET + 1;
  localparam int WIN_ELEMS   = MAX_WINDOW_FRAMES * MAX_FRAME_DIMS;

  localparam int POS_W   = $clog2(MAX_FRAME_DIMS);
  localparam int SLOT_W  = $clog2(RING_FRAMES);
  localparam int WADDR_W = $clog2(WIN_ELEMS);
  localparam int BIDX_W  = $clog2(MAX_BASIS);
  localparam int FIDX_W  = $clog2(MAX_WINDOW_FRAMES);
  localparam int COEF_W  = 16;
  localparam int PROD_W  = COEF_W + SAMPLE_BITS;
  localparam int ACC_W   = 48;
  localparam int WNUM_W  = 20;
  localparam int SPK_W   = 8;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_DIMS    = 2'd0;
  localparam logic [1:0] REG_WINDOW_FRAMES = 2'd1;
  localparam logic [1:0] REG_SKIP_FRAMES   = 2'd2;
  localparam logic [1:0] REG_BASIS_COUNT   = 2'd3;

  // action codes
  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_STIMULUS = 1'b1;

  typedef struct packed {
    logic [2:0]        basis_number;
    logic [ACC_W-1:0]  projection;
    logic [SPK_W-1:0]  window_spikes;
    logic [WNUM_W-1:0] window_number;
    logic              last;
  } result_t;

endpackage

### rtl/swbp_mac.sv
// Shared multiply-accumulate unit: registered product, then 48-bit wrapping accumulate.
module swbp_mac
  import swbp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          en,
  input  logic signed [COEF_W-1:0]      coef,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [ACC_W-1:0]              acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    prod <= coef * sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= en;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

### rtl/swbp_ctrl.sv
// Sequencer: frame ring, basis store, window bookkeeping and MAC operand fetch.
module swbp_ctrl
  import swbp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [8:0]                    cfg_val,
  input  logic                          in_take,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic                          in_chunk,
  input  logic [BIDX_W-1:0]             in_bidx,
  input  logic [WADDR_W-1:0]            in_addr,
  input  logic signed [COEF_W-1:0]      in_coef,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [SPK_W-1:0]              in_spikes,
  output logic                          mac_clr,
  output logic                          mac_en,
  output logic signed [COEF_W-1:0]      mac_coef,
  output logic signed [SAMPLE_BITS-1:0] mac_sample,
  input  logic [ACC_W-1:0]              mac_acc,
  output logic                          res_valid,
  input  logic                          res_take,
  output result_t                       res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;

  logic [8:0] frame_dims;
  logic [4:0] window_frames;
  logic [3:0] skip_frames;
  logic [3:0] basis_count;

  logic [8:0] dims_c;
  logic [4:0] wf_c;
  logic [3:0] nb_c;
  logic [5:0] span_sum;
  logic [4:0] span_c;

  logic [POS_W-1:0]  pos;
  logic [4:0]        fsc;
  logic [SLOT_W-1:0] ptr;
  logic [WNUM_W-1:0] wcount;

  // projection context, frozen for the whole window
  logic [8:0]         dims_l;
  logic [4:0]         wf_l;
  logic [3:0]         nb_l;
  logic [4:0]         span_l;
  logic [SLOT_W-1:0]  ptr_l;
  logic [SPK_W-1:0]   spikes_l;
  logic [WNUM_W-1:0]  wnum_l;

  logic [BIDX_W-1:0]  j;
  logic [FIDX_W-1:0]  f;
  logic [POS_W-1:0]   e;
  logic [WADDR_W-1:0] base;
  logic [1:0]         drain;

  logic signed [COEF_W-1:0]      basis_mem [0:MAX_BASIS*WIN_ELEMS-1];
  logic signed [SAMPLE_BITS-1:0] ring_mem  [0:RING_FRAMES*MAX_FRAME_DIMS-1];

  logic [POS_W-1:0]  pos_eff;
  logic [4:0]        fsc_eff;
  logic              frame_end;
  logic              stim_take;
  logic              load_take;
  logic              issue;
  logic              e_last;
  logic              f_last;
  logic              j_last;
  logic [SLOT_W-1:0] slot;

  always_comb begin
    dims_c   = (frame_dims == 9'd0) ? 9'd1 :
               (frame_dims > 9'(MAX_FRAME_DIMS)) ? 9'(MAX_FRAME_DIMS) : frame_dims;
    wf_c     = (window_frames == 5'd0) ? 5'd1 :
               (window_frames > 5'(MAX_WINDOW_FRAMES)) ? 5'(MAX_WINDOW_FRAMES) : window_frames;
    nb_c     = (basis_count == 4'd0) ? 4'd1 :
               (basis_count > 4'(MAX_BASIS)) ? 4'(MAX_BASIS) : basis_count;
    span_sum = {1'b0, wf_c} + {2'b0, skip_frames} - 6'd1;
    span_c   = span_sum[4:0];
  end

  assign in_ready  = (state == ST_IDLE);
  assign stim_take = in_take && (in_action == ACT_STIMULUS);
  assign load_take = in_take && (in_action == ACT_LOAD);
  assign pos_eff   = in_chunk ? '0 : pos;
  assign fsc_eff   = in_chunk ? 5'd0 : fsc;
  assign frame_end = ({1'b0, pos_eff} + 9'd1) >= dims_c;

  assign issue  = (state == ST_ISSUE);
  assign e_last = ({1'b0, e} == (dims_l - 9'd1));
  assign f_last = ({1'b0, f} == (wf_l - 5'd1));
  assign j_last = ({1'b0, j} == (nb_l - 4'd1));
  assign slot   = ptr_l - span_l + SLOT_W'(f);

  // basis store and frame ring
  always_ff @(posedge clk) begin
    if (load_take) begin
      basis_mem[{in_bidx, in_addr}] <= in_coef;
    end
    mac_coef <= basis_mem[{j, base + WADDR_W'(e)}];
  end

  always_ff @(posedge clk) begin
    if (stim_take) begin
      ring_mem[{ptr, pos_eff}] <= in_sample;
    end
    mac_sample <= ring_mem[{slot, e}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= issue;
    end
  end

  assign mac_clr = (stim_take && frame_end && (fsc_eff >= span_c)) ||
                   ((state == ST_EMIT) && res_take && !j_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_dims    <= 9'd192;
      window_frames <= 5'd1;
      skip_frames   <= 4'd0;
      basis_count   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_DIMS:    frame_dims    <= cfg_val;
        REG_WINDOW_FRAMES: window_frames <= cfg_val[4:0];
        REG_SKIP_FRAMES:   skip_frames   <= cfg_val[3:0];
        REG_BASIS_COUNT:   basis_count   <= cfg_val[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pos    <= '0;
      fsc    <= '0;
      ptr    <= '0;
      wcount <= '0;
      j      <= '0;
      f      <= '0;
      e      <= '0;
      base   <= '0;
      drain  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (stim_take) begin
            if (!frame_end) begin
              pos <= pos_eff + POS_W'(1);
              if (in_chunk) fsc <= '0;
            end else begin
              pos <= '0;
              ptr <= ptr + SLOT_W'(1);
              fsc <= (fsc_eff < 5'(RING_FRAMES - 1)) ? fsc_eff + 5'd1 : fsc_eff;
              if (fsc_eff >= span_c) begin
                wcount <= wcount + WNUM_W'(1);
                j      <= '0;
                f      <= '0;
                e      <= '0;
                base   <= '0;
                state  <= ST_ISSUE;
              end
            end
          end
        end
        ST_ISSUE: begin
          if (e_last) begin
            e    <= '0;
            base <= base + WADDR_W'(dims_l);
            if (f_last) begin
              drain <= '0;
              state <= ST_DRAIN;
            end else begin
              f <= f + FIDX_W'(1);
            end
          end else begin
            e <= e + POS_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the last product to land in the accumulator
          drain <= drain + 2'd1;
          if (drain == 2'd1) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_take) begin
            if (j_last) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + BIDX_W'(1);
              f     <= '0;
              e     <= '0;
              base  <= '0;
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stim_take && frame_end) begin
      dims_l   <= dims_c;
      wf_l     <= wf_c;
      nb_l     <= nb_c;
      span_l   <= span_c;
      ptr_l    <= ptr;
      spikes_l <= in_spikes;
      wnum_l   <= wcount;
    end
  end

  assign res_valid = (state == ST_EMIT);

  always_comb begin
    res.basis_number  = 3'(j);
    res.projection    = mac_acc;
    res.window_spikes = spikes_l;
    res.window_number = wnum_l;
    res.last          = j_last;
  end

endmodule

### rtl/sliding_window_basis_projection_core.sv
// Top level: stream ports, configuration port and output register around the sequencer.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: fields, tuser: action, chunk_start
//  m_axis    out  m_axis_tvalid/tready      tdata: result fields, tlast: last basis
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A load or a mid-frame element is taken with the sequencer staying idle. A frame end
// that closes a window runs basis_count * window_frames * frame_dims MACs on the single
// shared multiplier, one per cycle, then a drain and an emit state per basis vector.
// Input is held off until the last result of the window is in the output register.
// A stalled output holds the sequencer; reset is synchronous and needs no clearing pass.
module sliding_window_basis_projection_core
  import swbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // basis_index[2:0], coef_address[14:3], coef_value[30:15], sample[46:31],
  // spike_count[54:47], zero pad[55]
  input  logic [55:0] s_axis_tdata,
  // action[0], chunk_start[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // basis_number[2:0], projection[50:3], window_spikes[58:51],
  // window_number[78:59], zero pad[79]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic                          mac_clr;
  logic                          mac_en;
  logic signed [COEF_W-1:0]      mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic [ACC_W-1:0]              mac_acc;
  logic                          res_valid;
  logic                          res_take;
  result_t                       res;
  result_t                       out_reg;

  assign cfg_ready = 1'b1;
  assign res_take  = res_valid && (!m_axis_tvalid || m_axis_tready);

  swbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .in_take    (s_axis_tvalid && s_axis_tready),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser[0]),
    .in_chunk   (s_axis_tuser[1]),
    .in_bidx    (s_axis_tdata[2:0]),
    .in_addr    (s_axis_tdata[14:3]),
    .in_coef    (s_axis_tdata[30:15]),
    .in_sample  (s_axis_tdata[46:31]),
    .in_spikes  (s_axis_tdata[54:47]),
    .mac_clr    (mac_clr),
    .mac_en     (mac_en),
    .mac_coef   (mac_coef),
    .mac_sample (mac_sample),
    .mac_acc    (mac_acc),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  swbp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .clr    (mac_clr),
    .en     (mac_en),
    .coef   (mac_coef),
    .sample (mac_sample),
    .acc    (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_reg <= res;
  end

  assign m_axis_tdata = {1'b0, out_reg.window_number, out_reg.window_spikes,
                         out_reg.projection, out_reg.basis_number};
  assign m_axis_tlast = out_reg.last;

endmodule
